// File: hdl/rtfi_pkg.sv
`default_nettype none

package rtfi_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN = 1'b1;

    localparam logic [RATE_W-1:0] RATE_NUM_RESET = 32'd24;
    localparam logic [RATE_W-1:0] RATE_DEN_RESET = 32'd1;

    typedef struct packed {
        logic signed [WORD_W-1:0] time_numerator;
        logic signed [WORD_W-1:0] time_denominator;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] frame_index;
        logic                     valid_res;
    } t_out;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_MUL,
        OP_GCD
    } t_op;

    typedef struct packed {
        logic              start;
        t_op               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] rem;
        logic              ovf;
    } t_rsp;

endpackage

`default_nettype wire

// File: hdl/rational_time_frame_index_unit.sv
// a zero time or rate denominator skips the unit and goes straight to the output state;
// otherwise the shared iterative unit does the work, gcd one shift or subtract a cycle:
// two gcds, up to five divides and two multiplies per item
// throughput: one item at a time, the next beat is taken once the result is handed off
// reset: synchronous active low, rate registers return to 24/1, no beat pending
`default_nettype none

module rational_time_frame_index_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  rtfi_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output rtfi_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [rtfi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [rtfi_pkg::RATE_W-1:0]           i_cfg_data
);
    import rtfi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G1,
        ST_D1,
        ST_D2,
        ST_G2,
        ST_D3,
        ST_D4,
        ST_M1,
        ST_M2,
        ST_D5,
        ST_OUT
    } t_state;

    t_state            r_state;
    logic [RATE_W-1:0] r_rate_num;
    logic [RATE_W-1:0] r_rate_den;
    logic [WORD_W-1:0] r_tn;
    logic              r_tn_neg;
    logic [WORD_W-1:0] r_td;
    logic              r_td_neg;
    logic [RATE_W-1:0] r_rn;
    logic [RATE_W-1:0] r_rd;
    logic [WORD_W-1:0] r_g;
    logic [WORD_W-1:0] r_scaled;
    logic [WORD_W-1:0] r_res;
    logic              r_res_ok;
    t_cmd              r_cmd;
    t_out              r_out;
    logic              r_out_valid;

    t_rsp              w_rsp;
    logic [WORD_W-1:0] w_tn_mag;
    logic [WORD_W-1:0] w_td_mag;
    logic              w_res_neg;
    logic [WORD_W-1:0] w_res_floor;

    rtfi_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_tn_mag    = i_in_data.time_numerator[WORD_W-1]
                    ? (WORD_W'(0) - i_in_data.time_numerator) : i_in_data.time_numerator;
        w_td_mag    = i_in_data.time_denominator[WORD_W-1]
                    ? (WORD_W'(0) - i_in_data.time_denominator) : i_in_data.time_denominator;
        w_res_neg   = (r_scaled != '0) && (r_tn_neg != r_td_neg);
        w_res_floor = (w_rsp.rem != '0) ? ~w_rsp.quo : (WORD_W'(0) - w_rsp.quo);
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num <= RATE_NUM_RESET;
            r_rate_den <= RATE_DEN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RATE_NUM: r_rate_num <= i_cfg_data;
                CFG_RATE_DEN: r_rate_den <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_tn     <= w_tn_mag;
                        r_tn_neg <= i_in_data.time_numerator[WORD_W-1];
                        r_td     <= w_td_mag;
                        r_td_neg <= i_in_data.time_denominator[WORD_W-1];
                        r_rn     <= r_rate_num;
                        r_rd     <= r_rate_den;
                        if ((w_td_mag == '0) || (r_rate_den == '0)) begin
                            r_res    <= '0;
                            r_res_ok <= 1'b0;
                            r_state  <= ST_OUT;
                        end else begin
                            r_cmd.start <= 1'b1;
                            r_cmd.op    <= OP_GCD;
                            r_cmd.a     <= w_tn_mag;
                            r_cmd.b     <= {{(WORD_W-RATE_W){1'b0}}, r_rate_den};
                            r_state     <= ST_G1;
                        end
                    end
                end
                ST_G1: begin
                    if (w_rsp.done) begin
                        r_g         <= w_rsp.quo;
                        r_cmd.start <= 1'b1;
                        if (|w_rsp.quo[WORD_W-1:1]) begin
                            r_cmd.op <= OP_DIV;
                            r_cmd.a  <= r_tn;
                            r_cmd.b  <= w_rsp.quo;
                            r_state  <= ST_D1;
                        end else begin
                            r_cmd.op <= OP_GCD;
                            r_cmd.a  <= {{(WORD_W-RATE_W){1'b0}}, r_rn};
                            r_cmd.b  <= r_td;
                            r_state  <= ST_G2;
                        end
                    end
                end
                ST_D1: begin
                    if (w_rsp.done) begin
                        r_tn        <= w_rsp.quo;
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_DIV;
                        r_cmd.a     <= {{(WORD_W-RATE_W){1'b0}}, r_rd};
                        r_cmd.b     <= r_g;
                        r_state     <= ST_D2;
                    end
                end
                ST_D2: begin
                    if (w_rsp.done) begin
                        r_rd        <= w_rsp.quo[RATE_W-1:0];
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_GCD;
                        r_cmd.a     <= {{(WORD_W-RATE_W){1'b0}}, r_rn};
                        r_cmd.b     <= r_td;
                        r_state     <= ST_G2;
                    end
                end
                ST_G2: begin
                    if (w_rsp.done) begin
                        r_g         <= w_rsp.quo;
                        r_cmd.start <= 1'b1;
                        if (|w_rsp.quo[WORD_W-1:1]) begin
                            r_cmd.op <= OP_DIV;
                            r_cmd.a  <= {{(WORD_W-RATE_W){1'b0}}, r_rn};
                            r_cmd.b  <= w_rsp.quo;
                            r_state  <= ST_D3;
                        end else begin
                            r_cmd.op <= OP_MUL;
                            r_cmd.a  <= r_tn;
                            r_cmd.b  <= {{(WORD_W-RATE_W){1'b0}}, r_rn};
                            r_state  <= ST_M1;
                        end
                    end
                end
                ST_D3: begin
                    if (w_rsp.done) begin
                        r_rn        <= w_rsp.quo[RATE_W-1:0];
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_DIV;
                        r_cmd.a     <= r_td;
                        r_cmd.b     <= r_g;
                        r_state     <= ST_D4;
                    end
                end
                ST_D4: begin
                    if (w_rsp.done) begin
                        r_td        <= w_rsp.quo;
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_MUL;
                        r_cmd.a     <= r_tn;
                        r_cmd.b     <= {{(WORD_W-RATE_W){1'b0}}, r_rn};
                        r_state     <= ST_M1;
                    end
                end
                ST_M1: begin
                    if (w_rsp.done) begin
                        if (w_rsp.ovf) begin
                            r_res    <= '0;
                            r_res_ok <= 1'b0;
                            r_state  <= ST_OUT;
                        end else begin
                            r_scaled    <= w_rsp.quo;
                            r_cmd.start <= 1'b1;
                            r_cmd.op    <= OP_MUL;
                            r_cmd.a     <= r_td;
                            r_cmd.b     <= {{(WORD_W-RATE_W){1'b0}}, r_rd};
                            r_state     <= ST_M2;
                        end
                    end
                end
                ST_M2: begin
                    if (w_rsp.done) begin
                        if (w_rsp.ovf || (w_rsp.quo == '0)) begin
                            r_res    <= '0;
                            r_res_ok <= 1'b0;
                            r_state  <= ST_OUT;
                        end else begin
                            r_cmd.start <= 1'b1;
                            r_cmd.op    <= OP_DIV;
                            r_cmd.a     <= r_scaled;
                            r_cmd.b     <= w_rsp.quo;
                            r_state     <= ST_D5;
                        end
                    end
                end
                ST_D5: begin
                    if (w_rsp.done) begin
                        r_res    <= w_res_neg ? w_res_floor : w_rsp.quo;
                        r_res_ok <= 1'b1;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid       <= 1'b1;
                        r_out.frame_index <= r_res;
                        r_out.valid_res   <= r_res_ok;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // shared unit is only started while idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.start |-> !w_rsp.busy)
        else $error("unit started while busy");

    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_rsp.busy)
        else $error("unit busy with no item in flight");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> ((r_state != ST_IDLE) && (r_state != ST_OUT)))
        else $error("unit finished with no step waiting");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.valid_res) |-> (r_out.frame_index == '0))
        else $error("invalid beat carries nonzero index");

endmodule

`default_nettype wire

// File: hdl/rtfi_unit.sv
`default_nettype none

module rtfi_unit (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  rtfi_pkg::t_cmd i_cmd,
    output rtfi_pkg::t_rsp o_rsp
);
    import rtfi_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W) + 1;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATE_W - 1);

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_MUL,
        U_GPRE,
        U_GSTRIP,
        U_GRUN,
        U_GPOST,
        U_DONE
    } t_ustate;

    t_ustate           r_state;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_r;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;

    logic [WORD_W:0]   w_div_sh;
    logic [WORD_W+1:0] w_div_diff;
    logic              w_div_ge;
    logic [WORD_W:0]   w_mul_sum;
    logic [WORD_W:0]   w_g_ab;
    logic [WORD_W-1:0] w_g_ba;

    always_comb begin
        w_div_sh   = {r_r, r_x[WORD_W-1]};
        w_div_diff = {1'b0, w_div_sh} - {2'b00, r_y};
        w_div_ge   = !w_div_diff[WORD_W+1];
        w_mul_sum  = {1'b0, r_r} + (r_y[0] ? {1'b0, r_x} : '0);
        w_g_ab     = {1'b0, r_x} - {1'b0, r_y};
        w_g_ba     = r_y - r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_cmd.start) begin
                        r_ovf <= 1'b0;
                        r_cnt <= '0;
                        r_r   <= '0;
                        case (i_cmd.op)
                            OP_DIV: begin
                                r_x     <= i_cmd.a;
                                r_y     <= i_cmd.b;
                                r_state <= U_DIV;
                            end
                            OP_MUL: begin
                                r_x     <= i_cmd.a;
                                r_y     <= {{(WORD_W-RATE_W){1'b0}}, i_cmd.b[RATE_W-1:0]};
                                r_state <= U_MUL;
                            end
                            OP_GCD: begin
                                r_x <= i_cmd.a;
                                r_y <= i_cmd.b;
                                if (i_cmd.a == '0) begin
                                    r_x     <= i_cmd.b;
                                    r_state <= U_DONE;
                                end else if (i_cmd.b == '0) begin
                                    r_state <= U_DONE;
                                end else begin
                                    r_state <= U_GPRE;
                                end
                            end
                            default: r_state <= U_DONE;
                        endcase
                    end
                end
                U_DIV: begin
                    r_x   <= {r_x[WORD_W-2:0], w_div_ge};
                    r_r   <= w_div_ge ? w_div_diff[WORD_W-1:0] : w_div_sh[WORD_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= U_DONE;
                    end
                end
                U_MUL: begin
                    r_r   <= w_mul_sum[WORD_W:1];
                    r_y   <= {{(WORD_W-RATE_W){1'b0}}, w_mul_sum[0], r_y[RATE_W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_x     <= {w_mul_sum[WORD_W-RATE_W:1], w_mul_sum[0], r_y[RATE_W-1:1]};
                        r_ovf   <= |w_mul_sum[WORD_W:WORD_W-RATE_W];
                        r_state <= U_DONE;
                    end
                end
                U_GPRE: begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x   <= r_x >> 1;
                        r_y   <= r_y >> 1;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= U_GSTRIP;
                    end
                end
                U_GSTRIP: begin
                    if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else begin
                        r_state <= U_GRUN;
                    end
                end
                U_GRUN: begin
                    if (r_y == '0) begin
                        r_state <= U_GPOST;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (!w_g_ab[WORD_W] && (w_g_ab != '0)) begin
                        r_x <= r_y;
                        r_y <= w_g_ab[WORD_W-1:0];
                    end else begin
                        r_y <= w_g_ba;
                    end
                end
                U_GPOST: begin
                    if (r_cnt == '0) begin
                        r_state <= U_DONE;
                    end else begin
                        r_x   <= r_x << 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                U_DONE: r_state <= U_IDLE;
                default: r_state <= U_IDLE;
            endcase
        end
    end

    always_comb begin
        o_rsp.busy = (r_state != U_IDLE);
        o_rsp.done = (r_state == U_DONE);
        o_rsp.quo  = r_x;
        o_rsp.rem  = r_r;
        o_rsp.ovf  = r_ovf;
    end

endmodule

`default_nettype wire
